// ===== rtl/icy_metadata_demux_defines.svh =====
// Assertion macros used by the bound checker file (icy_checker.sv).
`ifndef ICY_METADATA_DEMUX_DEFINES_SVH
`define ICY_METADATA_DEMUX_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ICY_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ICY_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/icy_pkg.sv =====
package icy_pkg;

	// config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_META_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_META_INTERVAL = 2'd1;

	localparam int unsigned INTERVAL_RESET = 16000;

	localparam int META_LEFT_W = 12;
	localparam logic [7:0] NUL_BYTE = 8'h00;

	// front-to-back queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// what the back end must produce for one queued entry
	typedef enum logic [1:0] {
		K_AUDIO,
		K_META,
		K_META_LAST,
		K_SUP_LAST
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

endpackage

// ===== rtl/icy_front.sv =====
module icy_front #(
	parameter int INTERVAL_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icy_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [icy_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic [7:0]                       stream_byte,
	input  icy_pkg::fifo_stat_t              stat,
	output logic                             push,
	output icy_pkg::item_t                   push_item
);

	typedef enum logic [1:0] {
		PH_AUDIO,
		PH_SIZE,
		PH_META
	} phase_t;

	phase_t                             phase_q;
	logic                               enable_q;
	logic [INTERVAL_BITS-1:0]           interval_q;
	logic [INTERVAL_BITS-1:0]           audio_left_q;
	logic [icy_pkg::META_LEFT_W-1:0]    meta_left_q;
	logic                               nul_seen_q;

	logic                               accept;
	logic [INTERVAL_BITS-1:0]           audio_dec;
	logic [icy_pkg::META_LEFT_W-1:0]    meta_dec;
	logic [icy_pkg::META_LEFT_W-1:0]    meta_len;
	logic                               nul_now;

	assign accept    = in_valid && !stat.full;
	assign audio_dec = audio_left_q - INTERVAL_BITS'(1);
	assign meta_dec  = meta_left_q - icy_pkg::META_LEFT_W'(1);
	// length byte counts 16-byte units; result is taken mod 4096
	assign meta_len  = {stream_byte, 4'h0};
	assign nul_now   = nul_seen_q || (stream_byte == icy_pkg::NUL_BYTE);

	// what this byte gives the back end, if anything
	always_comb begin
		push           = 1'b0;
		push_item.kind = icy_pkg::K_AUDIO;
		push_item.data = stream_byte;
		if (accept) begin
			if (!enable_q) begin
				push = 1'b1;
			end else begin
				unique case (phase_q)
					PH_SIZE: begin
						push = 1'b0;
					end
					PH_META: begin
						if (meta_dec == '0) begin
							push           = 1'b1;
							push_item.kind = nul_now ? icy_pkg::K_SUP_LAST
							                         : icy_pkg::K_META_LAST;
						end else if (!nul_now) begin
							push           = 1'b1;
							push_item.kind = icy_pkg::K_META;
						end
					end
					default: begin
						push = (audio_left_q != '0);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_AUDIO;
			enable_q     <= 1'b0;
			interval_q   <= INTERVAL_BITS'(icy_pkg::INTERVAL_RESET);
			audio_left_q <= INTERVAL_BITS'(icy_pkg::INTERVAL_RESET);
			meta_left_q  <= '0;
			nul_seen_q   <= 1'b0;
		end else if (cfg_we) begin
			// any known register write restarts the demux
			case (cfg_idx)
				icy_pkg::REG_META_ENABLE: begin
					enable_q     <= cfg_data[0];
					phase_q      <= PH_AUDIO;
					audio_left_q <= interval_q;
					meta_left_q  <= '0;
					nul_seen_q   <= 1'b0;
				end
				icy_pkg::REG_META_INTERVAL: begin
					interval_q   <= INTERVAL_BITS'(cfg_data);
					phase_q      <= PH_AUDIO;
					audio_left_q <= INTERVAL_BITS'(cfg_data);
					meta_left_q  <= '0;
					nul_seen_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (accept && enable_q) begin
			unique case (phase_q)
				PH_SIZE: begin
					nul_seen_q <= 1'b0;
					if (stream_byte == '0) begin
						audio_left_q <= interval_q;
						phase_q      <= PH_AUDIO;
					end else begin
						meta_left_q <= meta_len;
						phase_q     <= PH_META;
					end
				end
				PH_META: begin
					nul_seen_q  <= nul_now;
					meta_left_q <= meta_dec;
					if (meta_dec == '0) begin
						audio_left_q <= interval_q;
						phase_q      <= PH_AUDIO;
					end
				end
				default: begin
					if (audio_left_q == '0) begin
						// zero interval: this byte is the length byte
						nul_seen_q <= 1'b0;
						if (stream_byte == '0) begin
							audio_left_q <= interval_q;
							phase_q      <= PH_AUDIO;
						end else begin
							meta_left_q <= meta_len;
							phase_q     <= PH_META;
						end
					end else begin
						audio_left_q <= audio_dec;
						phase_q      <= (audio_dec == '0) ? PH_SIZE : PH_AUDIO;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/icy_fifo.sv =====
module icy_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  icy_pkg::item_t        push_item,
	input  logic                  pop,
	output icy_pkg::item_t        head,
	output icy_pkg::fifo_stat_t   stat
);

	icy_pkg::item_t                 mem_q [icy_pkg::FIFO_DEPTH];
	logic [icy_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [icy_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [icy_pkg::FIFO_AW:0]      count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.full      = (count_q == (icy_pkg::FIFO_AW+1)'(icy_pkg::FIFO_DEPTH));
	assign stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/icy_back.sv =====
module icy_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  icy_pkg::fifo_stat_t   stat,
	input  icy_pkg::item_t        head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  is_meta,
	output logic                  byte_valid,
	output logic                  last_of_block
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       meta_q;
	logic       bvalid_q;
	logic       last_q;

	assign pop = stat.not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.kind)
				icy_pkg::K_AUDIO: begin
					byte_q <= head.data; meta_q <= 1'b0; bvalid_q <= 1'b1; last_q <= 1'b0;
				end
				icy_pkg::K_META: begin
					byte_q <= head.data; meta_q <= 1'b1; bvalid_q <= 1'b1; last_q <= 1'b0;
				end
				icy_pkg::K_META_LAST: begin
					byte_q <= head.data; meta_q <= 1'b1; bvalid_q <= 1'b1; last_q <= 1'b1;
				end
				default: begin
					// bare end-of-block marker
					byte_q <= '0; meta_q <= 1'b1; bvalid_q <= 1'b0; last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign is_meta       = meta_q;
	assign byte_valid    = bvalid_q;
	assign last_of_block = last_q;

endmodule

// ===== rtl/icy_metadata_demux.sv =====
// ICY metadata demultiplexer.
// Input channel: in_valid / in_stall carry one stream byte per transfer.
// Output channel: out_valid / out_stall carry one result per transfer:
//   out_byte, is_meta (audio or metadata), byte_valid (clear on a bare
//   end-of-block marker) and last_of_block.
// Config port: cfg_we / cfg_idx / cfg_data, index 0 meta_enable, 1
//   meta_interval; any valid write restarts the demux at the audio phase.
//   Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low, set by the front
//   end's single counter decrement and compare per byte.
// Path: each byte's result is written to the queue, then to the output
//   register. Length bytes and metadata bytes from the first NUL on give
//   no result, except a block's final byte.
// Reset: meta_enable 0, meta_interval 16000, audio phase, queue empty.
// Stall: out_stall holds a valid result in the output register; the
//   four-entry queue keeps taking bytes until full, then in_stall rises.
module icy_metadata_demux #(
	parameter int INTERVAL_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icy_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [icy_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       stream_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             is_meta,
	output logic                             byte_valid,
	output logic                             last_of_block
);

	icy_pkg::fifo_stat_t stat;
	icy_pkg::item_t      push_item;
	icy_pkg::item_t      head;
	logic                push;
	logic                pop;

	// front stalls only on a full queue
	assign in_stall = stat.full;

	// front: config registers, phase tracking, classification
	icy_front #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.stream_byte(stream_byte),
		.stat       (stat),
		.push       (push),
		.push_item  (push_item)
	);

	// decoupling queue
	icy_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// back: builds result fields into the output register
	icy_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.is_meta      (is_meta),
		.byte_valid   (byte_valid),
		.last_of_block(last_of_block)
	);

endmodule

// ===== rtl/icy_checker.sv =====
`include "icy_metadata_demux_defines.svh"

module icy_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       is_meta,
	input logic       byte_valid,
	input logic       last_of_block
);

	`ICY_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(is_meta) && $stable(byte_valid) && $stable(last_of_block), "stalled result changed")
	`ICY_ASSERT(a_audio_plain, out_valid && !is_meta, byte_valid && !last_of_block, "audio result marked as marker or block end")
	`ICY_ASSERT(a_marker_form, out_valid && !byte_valid, is_meta && last_of_block && (out_byte == 8'h00), "malformed end-of-block marker")
	`ICY_ASSERT(a_meta_no_nul, out_valid && is_meta && !last_of_block, out_byte != 8'h00, "NUL passed out inside metadata block")

endmodule

bind icy_metadata_demux icy_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.is_meta      (is_meta),
	.byte_valid   (byte_valid),
	.last_of_block(last_of_block)
);

// ===== tb/sv/icy_metadata_demux_checker.sv =====
`timescale 1ns / 100ps

// Watches the config port and both channels, keeps its own copy of the
// demux state and compares each output transfer with the oldest prediction.
module icy_metadata_demux_checker #(
	parameter int INTERVAL_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icy_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [icy_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [7:0]                       stream_byte,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [7:0]                       out_byte,
	input  logic                             is_meta,
	input  logic                             byte_valid,
	input  logic                             last_of_block,
	output int                               mismatch_count,
	output int                               outputs_due
);

	typedef enum logic [1:0] {
		PH_AUDIO,
		PH_SIZE,
		PH_META
	} demux_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       meta;
		logic       valid;
		logic       last;
	} demuxed_t;

	logic                              meta_on;
	logic [INTERVAL_BITS-1:0]          interval;
	demux_phase_t                      phase;
	logic [INTERVAL_BITS-1:0]          audio_left;
	logic [icy_pkg::META_LEFT_W-1:0]   meta_left;
	logic                              nul_seen;
	demuxed_t                          demuxed_q[$];
	int                                errs;

	function automatic void restart();
		phase      = PH_AUDIO;
		audio_left = interval;
		meta_left  = '0;
		nul_seen   = 1'b0;
	endfunction

	function automatic void queue_byte(input logic [7:0] data, input logic meta,
		input logic valid, input logic last);
		demuxed_t r;
		r.data  = data;
		r.meta  = meta;
		r.valid = valid;
		r.last  = last;
		demuxed_q.push_back(r);
	endfunction

	// length byte: value times 16, zero goes straight back to audio
	function automatic void take_length(input logic [7:0] b);
		meta_left = {b, 4'h0};
		nul_seen  = 1'b0;
		if (meta_left == 0) begin
			audio_left = interval;
			phase      = PH_AUDIO;
		end else begin
			phase = PH_META;
		end
	endfunction

	function automatic void split_stream_byte(input logic [7:0] b);
		if (!meta_on) begin
			queue_byte(b, 1'b0, 1'b1, 1'b0);
		end else begin
			case (phase)
				PH_SIZE: begin
					take_length(b);
				end
				PH_META: begin
					if (b == icy_pkg::NUL_BYTE)
						nul_seen = 1'b1;
					meta_left = meta_left - 1'b1;
					if (meta_left == 0) begin
						audio_left = interval;
						phase      = PH_AUDIO;
						if (nul_seen)
							queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
						else
							queue_byte(b, 1'b1, 1'b1, 1'b1);
					end else if (!nul_seen) begin
						queue_byte(b, 1'b1, 1'b1, 1'b0);
					end
				end
				default: begin
					phase = PH_AUDIO;
					if (audio_left == 0) begin
						take_length(b);
					end else begin
						audio_left = audio_left - 1'b1;
						if (audio_left == 0)
							phase = PH_SIZE;
						queue_byte(b, 1'b0, 1'b1, 1'b0);
					end
				end
			endcase
		end
	endfunction

	function automatic void check_result();
		demuxed_t want;
		if (demuxed_q.size() == 0) begin
			$error("result with nothing due: out_byte %h is_meta %b", out_byte, is_meta);
			errs++;
		end else begin
			want = demuxed_q.pop_front();
			if (out_byte !== want.data) begin
				$error("out_byte: expected %h, actual %h", want.data, out_byte);
				errs++;
			end
			if (is_meta !== want.meta) begin
				$error("is_meta: expected %b, actual %b", want.meta, is_meta);
				errs++;
			end
			if (byte_valid !== want.valid) begin
				$error("byte_valid: expected %b, actual %b", want.valid, byte_valid);
				errs++;
			end
			if (last_of_block !== want.last) begin
				$error("last_of_block: expected %b, actual %b", want.last, last_of_block);
				errs++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_on  = 1'b0;
			interval = INTERVAL_BITS'(icy_pkg::INTERVAL_RESET);
			restart();
			demuxed_q.delete();
			errs = 0;
			mismatch_count <= 0;
			outputs_due    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == icy_pkg::REG_META_ENABLE) begin
					meta_on = cfg_data[0];
					restart();
				end else if (cfg_idx == icy_pkg::REG_META_INTERVAL) begin
					interval = INTERVAL_BITS'(cfg_data);
					restart();
				end
			end
			if (in_valid && !in_stall)
				split_stream_byte(stream_byte);
			if (out_valid && !out_stall)
				check_result();
			mismatch_count <= errs;
			outputs_due    <= demuxed_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_icy_metadata_demux.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the ICY metadata demux. The checker instance
// does all prediction and comparison; this module only feeds bytes,
// writes the registers between phases and stalls the output side.
module tb_icy_metadata_demux;

	localparam int INTERVAL_BITS = 24;
	localparam int ITEM_GOAL     = 1350;
	// output passes through the queue and the output register; leave margin
	localparam int SETTLE_CYCLES = 4;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam logic [icy_pkg::CFG_IDX_W-1:0] REG_FIRST_SPARE = 2'd2;
	localparam logic [INTERVAL_BITS-1:0]      INTERVAL_MAX    = '1;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_we      = 1'b0;
	logic [icy_pkg::CFG_IDX_W-1:0]   cfg_idx     = '0;
	logic [icy_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [7:0]                      stream_byte = '0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [7:0]                      out_byte;
	logic                            is_meta;
	logic                            byte_valid;
	logic                            last_of_block;

	int mismatch_count;
	int outputs_due;
	int items_sent  = 0;
	int burst_left  = 0;
	int cycle_count = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_span = 0;
	int          stall_period = 2;
	int          stall_tick = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	icy_metadata_demux #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.is_meta      (is_meta),
		.byte_valid   (byte_valid),
		.last_of_block(last_of_block)
	);

	icy_metadata_demux_checker #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.is_meta       (is_meta),
		.byte_valid    (byte_valid),
		.last_of_block (last_of_block),
		.mismatch_count(mismatch_count),
		.outputs_due   (outputs_due)
	);

	// Output-side back-pressure. Every so often a new mode is picked:
	// no stall at all, occasional stall, mostly stalled, or a fixed duty
	// pattern whose period drifts against the sender's bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_span <= 0;
			stall_tick <= 0;
		end else begin
			if (stall_span == 0) begin
				stall_mode   <= stall_mode_t'($urandom_range(0, 3));
				stall_span   <= $urandom_range(32, 256);
				stall_period <= $urandom_range(2, 16);
			end else begin
				stall_span <= stall_span - 1;
			end
			stall_tick <= stall_tick + 1;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ((stall_tick % stall_period) < stall_period / 2);
			endcase
		end
	end

	// Hard stop for a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// One byte transfer. The sender runs in bursts; between bursts valid
	// drops for a random gap (sometimes none) and the idle payload is junk.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid    <= 1'b0;
				stream_byte <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Drop valid and wait until every predicted result has been seen,
	// then wait out the settle margin for bytes that make no result.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outputs_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high so back-to-back writes need no toggle; the caller
	// lowers it after the last write.
	task automatic write_reg(input logic [icy_pkg::CFG_IDX_W-1:0] idx,
		input logic [icy_pkg::CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// New setting while idle. Junk in the upper enable bits must be dropped,
	// and a write to an index past the register list must change nothing.
	task automatic setup(input logic en, input logic [INTERVAL_BITS-1:0] iv);
		settle();
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_FIRST_SPARE + icy_pkg::CFG_IDX_W'($urandom_range(0, 1)),
				icy_pkg::CFG_DATA_W'($urandom));
		write_reg(icy_pkg::REG_META_ENABLE,
			icy_pkg::CFG_DATA_W'(($urandom & 24'hFFFFFE) | en));
		write_reg(icy_pkg::REG_META_INTERVAL, iv);
		cfg_we <= 1'b0;
	endtask

	task automatic send_audio(input int n);
		repeat (n) send_byte(8'($urandom));
	endtask

	// Mostly tiny blocks, now and then a medium one.
	function automatic logic [7:0] pick_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 3)
			return 8'd0;
		else if (r < 12)
			return 8'($urandom_range(1, 2));
		else if (r < 15)
			return 8'($urandom_range(3, 6));
		return 8'($urandom_range(7, 20));
	endfunction

	// Length byte plus its metadata. Text is mostly printable with the odd
	// random nonzero byte; half the blocks hold a NUL somewhere, after which come
	// mostly zero pad bytes with some garbage that must stay hidden.
	task automatic send_block(input logic [7:0] len);
		int size;
		int nul_at;
		send_byte(len);
		size = len * 16;
		if (size > 0) begin
			nul_at = $urandom_range(0, 1) ? size : $urandom_range(0, size - 1);
			for (int i = 0; i < size; i++) begin
				if (i < nul_at)
					send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
						: $urandom_range(8'h20, 8'h7E)));
				else if (i == nul_at)
					send_byte(icy_pkg::NUL_BYTE);
				else
					send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom)
						: icy_pkg::NUL_BYTE);
			end
		end
	endtask

	// A well-formed run: a few interval+block units, sometimes closed off
	// by raw noise or a block cut short (the next setup restarts anyway).
	task automatic send_stream(input logic [INTERVAL_BITS-1:0] iv);
		int ending;
		int len;
		repeat ($urandom_range(1, 5)) begin
			send_audio(iv);
			send_block(pick_len());
		end
		ending = $urandom_range(0, 7);
		if (ending == 0) begin
			send_audio($urandom_range(1, 30));
		end else if (ending == 1) begin
			send_audio(iv);
			len = $urandom_range(1, 3);
			send_byte(8'(len));
			send_audio($urandom_range(0, len * 16 - 1));
		end
	endtask

	initial begin
		int r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: metadata off, every byte is plain audio.
		send_byte(8'h00);
		send_byte(8'hFF);

		// Enable only; interval stays at its reset value, so still audio.
		settle();
		write_reg(icy_pkg::REG_META_ENABLE, 24'h1);
		cfg_we <= 1'b0;
		send_byte(8'h55);
		send_byte(8'hAA);

		// Interval 2: audio, zero-length block straight back to audio,
		// then a 16-byte block with text, an early NUL, hidden garbage
		// and a suppressed final byte that still gives the end marker.
		setup(1'b1, INTERVAL_BITS'(2));
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h01);
		send_byte("T");
		send_byte("i");
		send_byte(8'hC3);
		send_byte(icy_pkg::NUL_BYTE);
		for (int i = 0; i < 11; i++)
			send_byte(i[0] ? 8'h41 : icy_pkg::NUL_BYTE);
		send_byte(8'h42);

		// Largest length byte (255 * 16 bytes), cut short by the next setup.
		setup(1'b1, INTERVAL_BITS'(1));
		send_audio(1);
		send_byte(8'hFF);
		send_audio(40);

		// Random phases, each with its own setting.
		while (items_sent < ITEM_GOAL) begin
			r = $urandom_range(0, 11);
			if (r == 0) begin
				setup(1'b0, INTERVAL_BITS'($urandom_range(0, INTERVAL_MAX)));
				send_audio($urandom_range(10, 50));
			end else if (r == 1) begin
				setup(1'b1, INTERVAL_MAX);
				send_audio($urandom_range(10, 40));
			end else if (r == 2) begin
				// zero interval: every audio-phase byte is a length byte
				setup(1'b1, INTERVAL_BITS'(0));
				send_stream(INTERVAL_BITS'(0));
			end else if (r == 3) begin
				setup(1'b1, INTERVAL_BITS'(1));
				send_stream(INTERVAL_BITS'(1));
			end else if (r == 4) begin
				// spare index written mid-stream: state must carry on
				settle();
				write_reg(REG_FIRST_SPARE + icy_pkg::CFG_IDX_W'($urandom_range(0, 1)),
					icy_pkg::CFG_DATA_W'($urandom));
				cfg_we <= 1'b0;
				send_audio($urandom_range(10, 40));
			end else begin
				r = $urandom_range(2, 40);
				setup(1'b1, INTERVAL_BITS'(r));
				send_stream(INTERVAL_BITS'(r));
			end
		end

		settle();
		if (mismatch_count == 0 && outputs_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/icy_pkg.sv
rtl/icy_front.sv
rtl/icy_fifo.sv
rtl/icy_back.sv
rtl/icy_metadata_demux.sv
rtl/icy_checker.sv
tb/sv/icy_metadata_demux_checker.sv
tb/sv/tb_icy_metadata_demux.sv
